### rtl/psar_pkg.sv
// Package: types and constants shared by the pulse slot address responder.
`timescale 1ns / 1ps

package psar_pkg;

    localparam int FRAME_W      = 15;
    localparam int INDEX_W      = 12;
    localparam int GAIN_W       = 4;
    localparam int ID_W         = 8;
    localparam int SLOTS        = 15;
    localparam int COUNT_W      = 4;
    localparam int ID_BITS      = 8;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 40;
    localparam int ADDR_W       = 4;
    localparam int BUF_SAMPLES  = 4096;

    localparam logic [COUNT_W-1:0] SLOT_LAST = 4'd14;
    localparam logic [COUNT_W-1:0] SLOT_FULL = 4'd15;

    localparam logic [ADDR_W-1:0] ADDR_BEACON_ID  = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_BASE_GAIN  = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_REPLY_GAIN = 4'h8;

    localparam logic [ID_W-1:0]   BEACON_ID_RST  = 8'd3;
    localparam logic [GAIN_W-1:0] BASE_GAIN_RST  = 4'd8;
    localparam logic [GAIN_W-1:0] REPLY_GAIN_RST = 4'd2;

    // slot positions that carry the id, most significant bit first
    localparam logic [COUNT_W-1:0] ID_SLOTS [ID_BITS] =
        '{4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12};

    typedef struct packed {
        logic [ID_W-1:0]   beacon_id;
        logic [GAIN_W-1:0] base_gain;
        logic [GAIN_W-1:0] reply_gain;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] out_frame;
        logic [INDEX_W-1:0] peak_index;
        logic [FRAME_W-1:0] peak_frame;
        logic               peak_found;
    } item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_value;
        logic               gain_write;
        logic [FRAME_W-1:0] ping_frame;
        logic [INDEX_W-1:0] ping_index;
        logic               ping_request;
    } result_t;

endpackage

### rtl/psar_cfg.sv
// Module: APB register file for beacon id and gain codes.
`timescale 1ns / 1ps

module psar_cfg
    import psar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_BEACON_ID:  cfg_next.beacon_id  = pwdata[ID_W-1:0];
                ADDR_BASE_GAIN:  cfg_next.base_gain  = pwdata[GAIN_W-1:0];
                ADDR_REPLY_GAIN: cfg_next.reply_gain = pwdata[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beacon_id  <= BEACON_ID_RST;
            cfg_reg.base_gain  <= BASE_GAIN_RST;
            cfg_reg.reply_gain <= REPLY_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_BEACON_ID:  prdata = {{(32-ID_W){1'b0}}, cfg_reg.beacon_id};
            ADDR_BASE_GAIN:  prdata = {{(32-GAIN_W){1'b0}}, cfg_reg.base_gain};
            ADDR_REPLY_GAIN: prdata = {{(32-GAIN_W){1'b0}}, cfg_reg.reply_gain};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### rtl/psar_core.sv
// Module: slot state registers and the per-beat decode of one polling step.
`timescale 1ns / 1ps

module psar_core
    import psar_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [SLOTS-1:0]   marks_reg,   marks_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               await_reg,   await_next;
    logic               pending_reg, pending_next;
    logic [FRAME_W-1:0] last_reg,    last_next;
    logic [ID_BITS-1:0] id_byte;

    // id byte from the marks; slot 14 itself is not an id slot
    always_comb
    begin
        for (int i = 0; i < ID_BITS; i++)
        begin
            id_byte[ID_BITS-1-i] = marks_reg[ID_SLOTS[i]];
        end
    end

    always_comb
    begin
        marks_next   = marks_reg;
        count_next   = count_reg;
        await_next   = await_reg;
        pending_next = pending_reg;
        last_next    = item.out_frame;
        res          = '0;

        if (item.out_frame != last_reg)
        begin
            if (count_reg != SLOT_FULL)
                count_next = count_reg + 1'b1;
            if (pending_reg)
            begin
                res.gain_write = 1'b1;
                res.gain_value = cfg.base_gain;
                pending_next   = 1'b0;
            end
        end

        if (!item.peak_found)
        begin
            if (count_next == SLOT_FULL && marks_reg[0])
                marks_next = '0;
        end
        else if (await_reg)
        begin
            await_next   = 1'b0;
            count_next   = '0;
            pending_next = 1'b1;
        end
        else
        begin
            if (!marks_reg[0])
                count_next = '0;
            if (count_next != SLOT_FULL)
                marks_next[count_next] = 1'b1;
            if (count_next == SLOT_LAST)
            begin
                if (id_byte == cfg.beacon_id)
                begin
                    res.ping_request = 1'b1;
                    res.ping_index   = INDEX_W'(item.peak_index % BUF_SAMPLES);
                    res.ping_frame   = item.peak_frame + 1'b1;
                    res.gain_write   = 1'b1;
                    res.gain_value   = cfg.reply_gain;
                    count_next       = '0;
                end
                await_next = 1'b1;
                marks_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg   <= '0;
            count_reg   <= '0;
            await_reg   <= 1'b1;
            pending_reg <= 1'b0;
            last_reg    <= '0;
        end
        else if (step)
        begin
            marks_reg   <= marks_next;
            count_reg   <= count_next;
            await_reg   <= await_next;
            pending_reg <= pending_next;
            last_reg    <= last_next;
        end
    end

endmodule

### rtl/pulse_slot_address_responder.sv
// Top level: pulse slot address responder with stream ports and APB registers.
//
//  channel | direction | beat / handshake          | payload
//  --------+-----------+---------------------------+---------------------------------
//  s_*     | in        | s_tvalid && s_tready      | one polling step (s_tdata)
//  m_*     | out       | m_tvalid && m_tready      | one result per step (m_tdata)
//  APB     | in/out    | psel && penable && pwrite | beacon_id, base_gain, reply_gain
//
//  One beat per cycle while m_tready is high, via input register then result register.
//  The step logic between the two registers updates the slot state as a beat moves on.
//  A stalled result holds m_tdata; an empty input register still takes one more beat.
//  rst_n resets all control and slot state and loads register defaults 3, 8, 2.
`timescale 1ns / 1ps

module pulse_slot_address_responder
    import psar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] peak_found, [15:1] peak_frame, [27:16] peak_index, [42:28] out_frame
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] ping_request, [12:1] ping_index, [27:13] ping_frame,
    // [28] gain_write, [32:29] gain_value
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_reg};

    psar_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psar_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        if (advance)
            out_reg <= res;
    end

endmodule

### rtl/psar_checker.sv
// Checker: port-level assertions for the pulse slot address responder, with bind.
`timescale 1ns / 1ps

module psar_checker
    import psar_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result beat changed while stalled");

    property p_stall_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready;
    endproperty
    a_stall: assert property (p_stall_only_when_full) else $error("input stalled with room");

    property p_ping_sets_gain;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[28];
    endproperty
    a_ping_gain: assert property (p_ping_sets_gain) else $error("ping without gain write");

    property p_no_ping_zero;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[27:1] == 27'd0;
    endproperty
    a_no_ping: assert property (p_no_ping_zero) else $error("ping fields set without ping");

    property p_no_gain_zero;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[28] |-> m_tdata[32:29] == 4'd0;
    endproperty
    a_no_gain: assert property (p_no_gain_zero) else $error("gain code set without write");

endmodule

bind pulse_slot_address_responder psar_checker u_psar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
